// File: design/bds_pkg.sv
// shared types and constants of the 2x2 box downscaler
// used by bds_ctrl, bds_avg, bds_line_store users and the top level
package bds_pkg;

	localparam int CHANNELS       = 4;
	localparam int CHAN_W         = 8;
	localparam int SUM_W          = CHAN_W + 1;
	localparam int CFG_W          = 13;
	localparam int CFG_IDX_W      = 2;
	localparam int NCH_W          = 3;
	localparam int HGT_W          = 13;
	localparam int ROW_W          = 12;
	localparam int MAX_HEIGHT     = 4096;
	localparam int MAX_CHANNELS   = 4;
	localparam int DEF_MAX_WIDTH  = 4096;

	localparam logic [CFG_W-1:0] RST_SRC_WIDTH     = 13'd2;
	localparam logic [CFG_W-1:0] RST_SRC_HEIGHT    = 13'd2;
	localparam logic [NCH_W-1:0] RST_CHANNEL_COUNT = 3'd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH     = 2'd0,
		REG_SRC_HEIGHT    = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_vec_t;
	typedef logic [CHANNELS-1:0][SUM_W-1:0]  sum_vec_t;

	// control word of the first pipeline stage
	typedef struct packed {
		logic valid;
		logic quad;
		logic last;
	} s1_ctrl_t;

endpackage

// File: design/bds_line_store.sv
// half-width line store: one write port, one read port, registered read data
// depends on nothing but its parameters
module bds_line_store #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11,
	parameter int DW    = 36
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: design/bds_ctrl.sv
// config registers, raster counters, left pixel and line store access,
// first pipeline stage; depends on bds_pkg
module bds_ctrl
	import bds_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	parameter int AW        = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pix_vec_t             in_pix,
	input  logic                 adv,
	output logic                 wr_en,
	output logic [AW-1:0]        wr_addr,
	output sum_vec_t             wr_data,
	output logic                 rd_en,
	output logic [AW-1:0]        rd_addr,
	output s1_ctrl_t             s1_ctrl,
	output sum_vec_t             s1_sum
);

	// column counter covers every source column up to MAX_WIDTH - 1
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	logic [CFG_W-1:0] src_width_q;
	logic [CFG_W-1:0] src_height_q;
	logic [NCH_W-1:0] channel_count_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	pix_vec_t         left_q;

	s1_ctrl_t s1_ctrl_s1;
	sum_vec_t s1_sum_s1;

	logic [WW-1:0]    w_eff, w_even;
	logic [HGT_W-1:0] h_eff, h_even;
	logic [NCH_W-1:0] nch;
	pix_vec_t         px;
	sum_vec_t         psum, sum_c;
	logic             acc, col_in, row_in, col_last, row_last;
	logic             emit_c, last_c, quad_c, load_left_c, wr_c, rd_c;
	logic             col_wrap, row_wrap;

	// clamped geometry
	always_comb begin
		if (src_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(src_width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(src_width_q);
		end
		if (src_height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (src_height_q > HGT_W'(MAX_HEIGHT)) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = src_height_q;
		end
		if (channel_count_q == '0) begin
			nch = NCH_W'(1);
		end else if (channel_count_q > NCH_W'(MAX_CHANNELS)) begin
			nch = NCH_W'(MAX_CHANNELS);
		end else begin
			nch = channel_count_q;
		end
	end

	assign w_even = {w_eff[WW-1:1], 1'b0};
	assign h_even = {h_eff[HGT_W-1:1], 1'b0};

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			px[ch]   = (NCH_W'(ch) < nch) ? in_pix[ch] : '0;
			psum[ch] = {1'b0, left_q[ch]} + {1'b0, px[ch]};
		end
	end

	assign col_in   = {1'b0, col_q} < w_even;
	assign row_in   = {1'b0, row_q} < h_even;
	assign col_last = ({1'b0, col_q} + WW'(1)) == w_even;
	assign row_last = ({1'b0, row_q} + HGT_W'(1)) == h_even;
	assign col_wrap = ({1'b0, col_q} + WW'(1)) >= w_eff;
	assign row_wrap = ({1'b0, row_q} + HGT_W'(1)) >= h_eff;

	// what the pixel at the current raster position does
	always_comb begin
		emit_c      = 1'b0;
		last_c      = 1'b0;
		quad_c      = 1'b0;
		load_left_c = 1'b0;
		wr_c        = 1'b0;
		rd_c        = 1'b0;
		sum_c       = psum;
		priority if (w_eff == WW'(1) && h_eff == HGT_W'(1)) begin
			emit_c = 1'b1;
			last_c = 1'b1;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				sum_c[ch] = {px[ch], 1'b0};
			end
		end else if (w_eff == WW'(1)) begin
			if (row_in) begin
				if (!row_q[0]) begin
					load_left_c = 1'b1;
				end else begin
					emit_c = 1'b1;
					last_c = row_last;
				end
			end
		end else if (h_eff == HGT_W'(1)) begin
			if (col_in) begin
				if (!col_q[0]) begin
					load_left_c = 1'b1;
				end else begin
					emit_c = 1'b1;
					last_c = col_last;
				end
			end
		end else begin
			if (col_in && row_in) begin
				if (!col_q[0]) begin
					load_left_c = 1'b1;
				end else if (!row_q[0]) begin
					wr_c = 1'b1;
				end else begin
					rd_c   = 1'b1;
					emit_c = 1'b1;
					quad_c = 1'b1;
					last_c = row_last && col_last;
				end
			end
		end
	end

	assign in_ready = !s1_ctrl_s1.valid || adv;
	assign acc      = in_valid && in_ready;
	assign wr_en    = acc && wr_c;
	assign rd_en    = acc && rd_c;
	assign wr_addr  = AW'(col_q >> 1);
	assign rd_addr  = AW'(col_q >> 1);
	assign wr_data  = psum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= RST_SRC_WIDTH;
			src_height_q    <= RST_SRC_HEIGHT;
			channel_count_q <= RST_CHANNEL_COUNT;
			col_q           <= '0;
			row_q           <= '0;
			left_q          <= '0;
		end else if (cfg_we && cfg_index <= CFG_IDX_W'(REG_CHANNEL_COUNT)) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:     src_width_q     <= cfg_data;
				REG_SRC_HEIGHT:    src_height_q    <= cfg_data;
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[NCH_W-1:0];
				default:           src_width_q     <= src_width_q;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
		end else if (acc) begin
			if (load_left_c) begin
				left_q <= px;
			end
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_ctrl_s1 <= '0;
		end else if (in_ready) begin
			s1_ctrl_s1.valid <= acc && emit_c;
			s1_ctrl_s1.quad  <= quad_c;
			s1_ctrl_s1.last  <= last_c;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			s1_sum_s1 <= sum_c;
		end
	end

	assign s1_ctrl = s1_ctrl_s1;
	assign s1_sum  = s1_sum_s1;

`ifndef ASSERT_OFF
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, col_q} < w_eff) && ({1'b0, row_q} < h_eff))
		else $error("raster position outside the frame");
	a_read_feeds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> s1_ctrl_s1.valid && s1_ctrl_s1.quad)
		else $error("line store read without a block average in stage 1");
	a_single_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("line store written and read in one cycle");
`endif

endmodule

// File: design/bds_avg.sv
// final rounding of pair and block sums and the output register
// depends on bds_pkg
module bds_avg
	import bds_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  s1_ctrl_t s1_ctrl,
	input  sum_vec_t s1_sum,
	input  sum_vec_t rd_sum,
	output logic     adv,
	output logic     out_valid,
	input  logic     out_ready,
	output pix_vec_t out_pix,
	output logic     out_last
);

	logic     out_valid_q;
	logic     out_last_q;
	pix_vec_t out_pix_q;
	pix_vec_t res;

	logic [SUM_W+1:0] quad_sum [CHANNELS];
	logic [SUM_W:0]   pair_sum [CHANNELS];

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++) begin
			quad_sum[ch] = {2'b00, rd_sum[ch]} + {2'b00, s1_sum[ch]} + (SUM_W+2)'(2);
			pair_sum[ch] = {1'b0, s1_sum[ch]} + (SUM_W+1)'(1);
			res[ch] = s1_ctrl.quad ? quad_sum[ch][SUM_W:2] : pair_sum[ch][SUM_W-1:1];
		end
	end

	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= s1_ctrl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_ctrl.valid) begin
			out_pix_q  <= res;
			out_last_q <= s1_ctrl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

endmodule

// File: design/box_downscale_2x2_unit.sv
// 2x2 box downscaler, one mip level from a raster pixel stream
// each result passes the stage 1 register and the output register on its way to the master side
// throughput: one pixel per clock unless the master side stalls; the line store serves
// one write or one read per accepted pixel, so it never limits the rate
// reset: arst_n clears counters, left pixel and pipeline valids at once; no clearing pass,
// the line store is only read where the upper row of the same frame wrote it
module box_downscale_2x2_unit
	import bds_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	// source pixels
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [31:0]          s_axis_tdata,   // chan0, chan1, chan2, chan3
	// downscaled pixels
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // out0, out1, out2, out3
	output logic                 m_axis_tlast    // frame_last
);

	// half a line of pair sums; address is the source column divided by two
	localparam int STORE_DEPTH = MAX_WIDTH / 2;
	localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	logic          wr_en, rd_en, adv;
	logic [AW-1:0] wr_addr, rd_addr;
	sum_vec_t      wr_data, rd_data;
	s1_ctrl_t      s1_ctrl;
	sum_vec_t      s1_sum;
	pix_vec_t      out_pix;

	// front end: raster position, left pixel, line store write on the upper row,
	// read on the lower row; read data lines up with stage 1
	bds_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.AW        (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pix    (pix_vec_t'(s_axis_tdata)),
		.adv       (adv),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.s1_ctrl   (s1_ctrl),
		.s1_sum    (s1_sum)
	);

	// upper row pair sums, four 9-bit channels per entry
	bds_line_store #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW),
		.DW    (CHANNELS * SUM_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// rounding and output register; a stalled result keeps stage 1 and the
	// store read data frozen since no new transaction is taken
	bds_avg u_avg (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_ctrl   (s1_ctrl),
		.s1_sum    (s1_sum),
		.rd_sum    (rd_data),
		.adv       (adv),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (out_pix),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = out_pix;

endmodule

// File: tb/sv/box_downscale_2x2_unit_tb.sv
// self-checking testbench of the 2x2 box downscaler: a pixel predictor in the bench
// forms the expected mip level, which is compared with every master-side transaction
// depends on bds_pkg and box_downscale_2x2_unit
module box_downscale_2x2_unit_tb
	import bds_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          RANDOM_ITEMS = 950;
	localparam int unsigned QUIET_LIMIT  = 1000;
	localparam int          PIPE_SETTLE  = 4;
	localparam int          MAX_REPORTS  = 10;
	localparam int          LONG_RUN     = 200;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_W-1:0]     cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata  = '0;   // chan0, chan1, chan2, chan3
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;         // out0, out1, out2, out3
	logic                 m_axis_tlast;         // frame_last

	box_downscale_2x2_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #6 clk = ~clk;

	// one output pixel of the mip level
	typedef struct packed {
		logic     last;
		pix_vec_t px;
	} mip_px_t;

	// predictor state: registers as written, line store, left pixel, raster position
	logic [CFG_W-1:0] width_reg  = RST_SRC_WIDTH;
	logic [CFG_W-1:0] height_reg = RST_SRC_HEIGHT;
	logic [NCH_W-1:0] chans_reg  = RST_CHANNEL_COUNT;
	sum_vec_t         pair_sums [DEF_MAX_WIDTH/2];
	pix_vec_t         left_px    = '0;
	int unsigned      col_pos    = 0;
	int unsigned      row_pos    = 0;

	mip_px_t     mip_q[$];
	int unsigned mismatch_cnt = 0;
	int unsigned quiet_cycles = 0;
	bit          src_idle_en  = 1'b1;
	bit          sink_idle_en = 1'b1;

	// register values as the block uses them: zero reads as one, large values saturate
	function automatic void eff_dims(output int unsigned w, output int unsigned h,
			output int unsigned n);
		w = (width_reg == 0) ? 1 : (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		n = (chans_reg == 0) ? 1 : (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : chans_reg;
	endfunction

	function automatic int unsigned frame_pixels();
		int unsigned w, h, n;
		eff_dims(w, h, n);
		return w * h;
	endfunction

	// advance the downscaler by one source pixel, queue the mip pixel if one is due
	task automatic predict_mip(input pix_vec_t in_px);
		int unsigned w, h, n, even_w, even_h, slot;
		pix_vec_t    px;
		mip_px_t     res;
		bit          emit;
		eff_dims(w, h, n);
		even_w = w & ~32'd1;
		even_h = h & ~32'd1;
		slot   = col_pos >> 1;
		res    = '0;
		emit   = 1'b0;
		for (int c = 0; c < CHANNELS; c++)
			px[c] = (c < n) ? in_px[c] : '0;

		if (w == 1 && h == 1) begin
			// single pixel level, copied through
			res.px   = px;
			res.last = 1'b1;
			emit     = 1'b1;
		end else if (w == 1) begin
			// vertical pairs
			if (row_pos < even_h) begin
				if (row_pos[0] == 1'b0) begin
					left_px = px;
				end else begin
					for (int c = 0; c < CHANNELS; c++)
						res.px[c] = CHAN_W'((int'(left_px[c]) + int'(px[c]) + 1) >> 1);
					res.last = (row_pos == even_h - 1);
					emit     = 1'b1;
				end
			end
		end else if (h == 1) begin
			// horizontal pairs
			if (col_pos < even_w) begin
				if (col_pos[0] == 1'b0) begin
					left_px = px;
				end else begin
					for (int c = 0; c < CHANNELS; c++)
						res.px[c] = CHAN_W'((int'(left_px[c]) + int'(px[c]) + 1) >> 1);
					res.last = (col_pos == even_w - 1);
					emit     = 1'b1;
				end
			end
		end else if (col_pos < even_w && row_pos < even_h) begin
			if (col_pos[0] == 1'b0) begin
				left_px = px;
			end else if (row_pos[0] == 1'b0) begin
				// upper row of the block: keep the pair sum for the lower row
				for (int c = 0; c < CHANNELS; c++)
					pair_sums[slot][c] = SUM_W'(int'(left_px[c]) + int'(px[c]));
			end else begin
				for (int c = 0; c < CHANNELS; c++)
					res.px[c] = CHAN_W'((int'(pair_sums[slot][c]) + int'(left_px[c])
						+ int'(px[c]) + 2) >> 2);
				res.last = (row_pos == even_h - 1) && (col_pos == even_w - 1);
				emit     = 1'b1;
			end
		end

		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
		if (emit)
			mip_q.push_back(res);
	endtask

	task automatic flag_mismatch(input string msg);
		if (mismatch_cnt < MAX_REPORTS)
			$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	// one source transaction; tvalid stays high when the next pixel follows at once
	task automatic send_pixel(input pix_vec_t px);
		int unsigned gap;
		gap = src_idle_en ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		predict_mip(px);
	endtask

	task automatic send_random(input int unsigned count);
		repeat (count) send_pixel(pix_vec_t'($urandom));
	endtask

	// stop the source and let every expected pixel and the pipeline drain
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (mip_q.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	// register write while idle; every write restarts the frame
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SRC_WIDTH:     width_reg = val;
			REG_SRC_HEIGHT:    height_reg = val;
			REG_CHANNEL_COUNT: chans_reg = val[NCH_W-1:0];
			default: ;
		endcase
		left_px = '0;
		col_pos = 0;
		row_pos = 0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
			input logic [CFG_W-1:0] n);
		write_reg(REG_SRC_WIDTH, w);
		write_reg(REG_SRC_HEIGHT, h);
		write_reg(REG_CHANNEL_COUNT, n);
	endtask

	// reset values: 2x2 source, four channels, rounding of the 2x2 average
	task automatic test_default_block();
		send_pixel({8'd2, 8'd1, 8'd0, 8'hFF});
		send_pixel({8'd0, 8'd0, 8'd0, 8'hFF});
		send_pixel({8'd0, 8'd0, 8'd0, 8'hFF});
		send_pixel({8'd0, 8'd0, 8'd0, 8'hFF});
	endtask

	// width 1: vertical pairs, trailing odd row dropped, channel 3 unused
	task automatic test_vertical_pairs();
		configure(13'd1, 13'd3, 13'd3);
		send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'hFF, 8'h01, 8'h00, 8'hFF});
		send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
	endtask

	// height 1: horizontal pairs, trailing odd column dropped
	task automatic test_horizontal_pairs();
		configure(13'd5, 13'd1, 13'd2);
		send_pixel({8'hFF, 8'hFF, 8'hFF, 8'h00});
		send_pixel({8'hFF, 8'hFF, 8'h00, 8'hFF});
		send_random(3);
	endtask

	// zero width, height and channel count read as one: 1x1 copy of channel 0
	task automatic test_single_pixel();
		configure(13'd0, 13'd0, 13'd0);
		send_pixel({8'hFF, 8'hFF, 8'hFF, 8'hFF});
		send_pixel({8'h00, 8'h00, 8'h00, 8'h80});
	endtask

	// odd width and height, channel count above the limit saturates to four
	task automatic test_odd_edges();
		configure(13'd3, 13'd3, 13'd7);
		send_random(9);
	endtask

	// a write in the middle of a frame starts the frame over
	task automatic test_restart();
		configure(13'd2, 13'd2, 13'd4);
		send_random(3);
		write_reg(REG_SRC_WIDTH, 13'd2);
		send_random(4);
	endtask

	// saturated width: start of a long single line as back to back horizontal pairs
	task automatic test_max_width();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		configure(13'h1FFF, 13'd1, 13'd4);
		send_random(LONG_RUN);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// tallest column of single pixels, first part only
	task automatic test_max_height();
		src_idle_en  = 1'b0;
		sink_idle_en = 1'b0;
		configure(13'd1, 13'd4096, 13'd4);
		send_random(LONG_RUN);
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	function automatic logic [CFG_W-1:0] pick_dim(input int unsigned hi_big,
			input int unsigned hi_small);
		if ($urandom_range(0, 19) == 0)
			return '0;
		return CFG_W'($urandom_range(1, ($urandom_range(0, 3) == 0) ? hi_big : hi_small));
	endfunction

	// random sizes and channel counts, whole frames mostly, some frames cut short
	task automatic test_random_frames();
		int unsigned sent, cut;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			src_idle_en  = ($urandom_range(0, 3) != 0);
			sink_idle_en = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SRC_WIDTH, pick_dim(40, 6));
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_SRC_HEIGHT, pick_dim(8, 4));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_CHANNEL_COUNT, CFG_W'($urandom_range(0, 8191)));
			repeat ($urandom_range(1, 3)) begin
				send_random(frame_pixels());
				sent += frame_pixels();
			end
			if ($urandom_range(0, 5) == 0) begin
				cut = $urandom_range(1, frame_pixels());
				send_random(cut);
				sent += cut;
			end
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	// master side: random stall before each result, none while idling is off
	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = sink_idle_en ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		mip_px_t  want;
		pix_vec_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (mip_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected transaction data %h last %b",
					got, m_axis_tlast));
			end else begin
				want = mip_q.pop_front();
				for (int c = 0; c < CHANNELS; c++)
					if (got[c] !== want.px[c])
						flag_mismatch($sformatf("out%0d expected %h actual %h",
							c, want.px[c], got[c]));
				if (m_axis_tlast !== want.last)
					flag_mismatch($sformatf("frame_last expected %b actual %b",
						want.last, m_axis_tlast));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("box_downscale_2x2_unit test failed");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_block();
		test_vertical_pairs();
		test_horizontal_pairs();
		test_single_pixel();
		test_odd_edges();
		test_restart();
		test_max_width();
		test_max_height();
		test_random_frames();
		drain();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("box_downscale_2x2_unit test passed");
		else
			$display("box_downscale_2x2_unit test failed");
		$finish;
	end

endmodule
